FILE: sv/ssp_pkg.sv
// Shared types, constants and helper functions for the SOCKS5 handshake parser.
package ssp_pkg;

  // Input operation codes.
  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_OUTCOME = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Result kinds.
  localparam logic [1:0] K_REPLY = 2'd0;
  localparam logic [1:0] K_ADDR  = 2'd1;
  localparam logic [1:0] K_DONE  = 2'd2;
  localparam logic [1:0] K_ERR   = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_GREET_VER = 3'd0;
  localparam logic [2:0] ERR_REQ_VER   = 3'd1;
  localparam logic [2:0] ERR_COMMAND   = 3'd2;
  localparam logic [2:0] ERR_IPV6      = 3'd3;
  localparam logic [2:0] ERR_ATYP      = 3'd4;

  // Protocol bytes.
  localparam logic [7:0] SOCKS_VER    = 8'h05;
  localparam logic [7:0] METHOD_NONE  = 8'h00;
  localparam logic [7:0] CMD_CONNECT  = 8'h01;
  localparam logic [7:0] ATYP_IPV4    = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN  = 8'h03;
  localparam logic [7:0] ATYP_IPV6    = 8'h04;
  localparam logic [7:0] REP_OK       = 8'h00;
  localparam logic [7:0] REP_FAIL     = 8'h01;
  localparam logic [7:0] REP_ATYP     = 8'h05;
  localparam logic [7:0] REP_CMD      = 8'h07;
  localparam logic [7:0] IPV4_LEN     = 8'd4;

  // Command queue between the parser and the result sequencer.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int BEAT_W = 4;
  localparam logic [BEAT_W-1:0] REPLY_LEN = BEAT_W'(10);

  typedef enum logic [3:0] {
    PH_GVER, PH_GNMETH, PH_METHODS, PH_RVER, PH_RCMD, PH_RRSV, PH_RATYP,
    PH_IPV4, PH_DLEN, PH_DOMAIN, PH_PORTHI, PH_PORTLO, PH_WAIT, PH_HALT
  } phase_t;

  typedef enum logic [2:0] {
    CMD_REPLY2, CMD_REPLY10, CMD_REPLY10_ERR, CMD_ADDR, CMD_DONE, CMD_ERR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [7:0]  data;
    logic [15:0] port;
    logic        ak;
    logic [7:0]  hl;
    logic [2:0]  err;
  } cmd_t;

  function automatic logic [BEAT_W-1:0] cmd_beats(input cmd_op_t op);
    logic [BEAT_W-1:0] n;
    case (op)
      CMD_REPLY2:      n = BEAT_W'(2);
      CMD_REPLY10:     n = REPLY_LEN;
      CMD_REPLY10_ERR: n = REPLY_LEN + BEAT_W'(1);
      default:         n = BEAT_W'(1);
    endcase
    return n;
  endfunction

  // Ten-byte reply: 05 REP 00 01 00 00 00 00 00 00.
  function automatic logic [7:0] reply_byte(input logic [BEAT_W-1:0] idx,
                                            input logic [7:0] rep);
    logic [7:0] b;
    case (idx)
      BEAT_W'(0): b = SOCKS_VER;
      BEAT_W'(1): b = rep;
      BEAT_W'(3): b = ATYP_IPV4;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: sv/socks5_handshake_parser.sv
// Top level of the SOCKS5 CONNECT handshake parser.
// An accepted item's command is queued, then its first result is registered for output.
// Throughput: one item per cycle in, one result per cycle out; the parser stalls only
// when the four-entry command queue fills, behind a ten- or eleven-item reply burst or
// a receiver that holds off.
// Reset: synchronous rst empties the queue and output stage and returns the parser
// to expecting the greeting version.
module socks5_handshake_parser import ssp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op,
  input  logic [7:0]  client_byte,
  input  logic        connect_ok,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [15:0] dest_port,
  output logic        addr_kind,
  output logic [7:0]  host_length,
  output logic [2:0]  error_code,
  output logic        last
);

  logic cmd_valid, q_empty, q_pop;
  cmd_t cmd, head;

  ssp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (push && !full),
    .op          (op),
    .client_byte (client_byte),
    .connect_ok  (connect_ok),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd)
  );

  ssp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_valid),
    .wr_cmd  (cmd),
    .rd_en   (q_pop),
    .rd_cmd  (head),
    .q_empty (q_empty),
    .q_full  (full)
  );

  ssp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .head        (head),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .kind        (kind),
    .data_byte   (data_byte),
    .dest_port   (dest_port),
    .addr_kind   (addr_kind),
    .host_length (host_length),
    .error_code  (error_code),
    .last        (last)
  );

endmodule

FILE: sv/ssp_front.sv
// Handshake parser: consumes one item per cycle unless the queue is full, and issues commands to the queue.
module ssp_front import ssp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [1:0] op,
  input  logic [7:0] client_byte,
  input  logic       connect_ok,
  output logic       cmd_valid,
  output cmd_t       cmd
);

  phase_t      phase, phase_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic        address_kind, address_kind_next;
  logic [7:0]  port_high, port_high_next;
  logic [7:0]  address_length, address_length_next;
  logic [1:0]  req_flags, req_flags_next;
  logic [7:0]  bytes_dec;

  assign bytes_dec = bytes_left - 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_GVER;
      bytes_left     <= '0;
      address_kind   <= 1'b0;
      port_high      <= '0;
      address_length <= '0;
      req_flags      <= '0;
    end else begin
      phase          <= phase_next;
      bytes_left     <= bytes_left_next;
      address_kind   <= address_kind_next;
      port_high      <= port_high_next;
      address_length <= address_length_next;
      req_flags      <= req_flags_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    bytes_left_next     = bytes_left;
    address_kind_next   = address_kind;
    port_high_next      = port_high;
    address_length_next = address_length;
    req_flags_next      = req_flags;
    if (accept) begin
      if (op == OP_BYTE) begin
        case (phase)
          PH_GVER: begin
            req_flags_next = {1'b0, client_byte != SOCKS_VER};
            phase_next     = PH_GNMETH;
          end
          PH_GNMETH: begin
            if (req_flags[0]) begin
              phase_next = PH_HALT;
            end else if (client_byte == METHOD_NONE) begin
              phase_next = PH_RVER;
            end else begin
              bytes_left_next = client_byte;
              phase_next      = PH_METHODS;
            end
          end
          PH_METHODS: begin
            bytes_left_next = bytes_dec;
            if (bytes_dec == 8'd0) begin
              phase_next = PH_RVER;
            end
          end
          PH_RVER: begin
            req_flags_next = {1'b0, client_byte != SOCKS_VER};
            phase_next     = PH_RCMD;
          end
          PH_RCMD: begin
            req_flags_next = {req_flags[1] | (client_byte != CMD_CONNECT), req_flags[0]};
            phase_next     = PH_RRSV;
          end
          PH_RRSV: begin
            phase_next = PH_RATYP;
          end
          PH_RATYP: begin
            if (req_flags != 2'b00) begin
              phase_next = PH_HALT;
            end else if (client_byte == ATYP_IPV4) begin
              address_kind_next   = 1'b0;
              address_length_next = IPV4_LEN;
              bytes_left_next     = IPV4_LEN;
              phase_next          = PH_IPV4;
            end else if (client_byte == ATYP_DOMAIN) begin
              address_kind_next = 1'b1;
              phase_next        = PH_DLEN;
            end else begin
              phase_next = PH_HALT;
            end
          end
          PH_IPV4, PH_DOMAIN: begin
            bytes_left_next = bytes_dec;
            if (bytes_dec == 8'd0) begin
              phase_next = PH_PORTHI;
            end
          end
          PH_DLEN: begin
            address_length_next = client_byte;
            bytes_left_next     = client_byte;
            phase_next          = (client_byte == 8'd0) ? PH_PORTHI : PH_DOMAIN;
          end
          PH_PORTHI: begin
            port_high_next = client_byte;
            phase_next     = PH_PORTLO;
          end
          PH_PORTLO: begin
            phase_next = PH_WAIT;
          end
          default: begin
          end
        endcase
      end else if (op == OP_OUTCOME) begin
        if (phase == PH_WAIT) begin
          phase_next = PH_HALT;
        end
      end else if (op == OP_RESTART) begin
        phase_next          = PH_GVER;
        bytes_left_next     = '0;
        address_kind_next   = 1'b0;
        port_high_next      = '0;
        address_length_next = '0;
        req_flags_next      = '0;
      end
    end
  end

  always_comb begin
    cmd_valid = 1'b0;
    cmd       = '{op: CMD_ERR, data: '0, port: '0, ak: 1'b0, hl: '0, err: '0};
    if (accept) begin
      if (op == OP_BYTE) begin
        case (phase)
          PH_GNMETH: begin
            cmd_valid = 1'b1;
            if (req_flags[0]) begin
              cmd.op  = CMD_ERR;
              cmd.err = ERR_GREET_VER;
            end else begin
              cmd_valid = (client_byte == METHOD_NONE);
              cmd.op    = CMD_REPLY2;
            end
          end
          PH_METHODS: begin
            cmd_valid = (bytes_dec == 8'd0);
            cmd.op    = CMD_REPLY2;
          end
          PH_RATYP: begin
            cmd_valid = 1'b1;
            if (req_flags[0]) begin
              cmd.op  = CMD_ERR;
              cmd.err = ERR_REQ_VER;
            end else if (req_flags[1]) begin
              cmd.op   = CMD_REPLY10_ERR;
              cmd.data = REP_CMD;
              cmd.err  = ERR_COMMAND;
            end else if (client_byte == ATYP_IPV4 || client_byte == ATYP_DOMAIN) begin
              cmd_valid = 1'b0;
            end else if (client_byte == ATYP_IPV6) begin
              cmd.op   = CMD_REPLY10_ERR;
              cmd.data = REP_ATYP;
              cmd.err  = ERR_IPV6;
            end else begin
              cmd.op  = CMD_ERR;
              cmd.err = ERR_ATYP;
            end
          end
          PH_IPV4, PH_DOMAIN: begin
            cmd_valid = 1'b1;
            cmd.op    = CMD_ADDR;
            cmd.data  = client_byte;
            cmd.ak    = address_kind;
          end
          PH_PORTLO: begin
            cmd_valid = 1'b1;
            cmd.op    = CMD_DONE;
            cmd.port  = {port_high, client_byte};
            cmd.ak    = address_kind;
            cmd.hl    = address_length;
          end
          default: begin
          end
        endcase
      end else if (op == OP_OUTCOME && phase == PH_WAIT) begin
        cmd_valid = 1'b1;
        cmd.op    = CMD_REPLY10;
        cmd.data  = connect_ok ? REP_OK : REP_FAIL;
      end
    end
  end

endmodule

FILE: sv/ssp_queue.sv
// Short command queue that decouples the parser from the result sequencer.
module ssp_queue import ssp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  input  logic rd_en,
  output cmd_t rd_cmd,
  output logic q_empty,
  output logic q_full
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_empty = (count == '0);
  assign q_full  = (count == QCNT_W'(QDEPTH));
  assign rd_cmd  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/ssp_back.sv
// Result sequencer: expands queued commands into result items behind an output register.
module ssp_back import ssp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  cmd_t        head,
  output logic        q_pop,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [15:0] dest_port,
  output logic        addr_kind,
  output logic [7:0]  host_length,
  output logic [2:0]  error_code,
  output logic        last
);

  logic              out_valid, out_valid_next;
  logic [BEAT_W-1:0] beat, beat_next;
  logic              adv, last_beat, taken;
  logic [1:0]        r_kind;
  logic [7:0]        r_data;
  logic [15:0]       r_port;
  logic              r_ak;
  logic [7:0]        r_hl;
  logic [2:0]        r_err;

  assign taken     = pop && out_valid;
  assign adv       = !q_empty && (!out_valid || taken);
  assign last_beat = (beat == cmd_beats(head.op) - BEAT_W'(1));
  assign q_pop     = adv && last_beat;
  assign empty     = !out_valid;

  always_comb begin
    beat_next      = adv ? (last_beat ? '0 : beat + BEAT_W'(1)) : beat;
    out_valid_next = adv ? 1'b1 : (taken ? 1'b0 : out_valid);
  end

  always_comb begin
    r_kind = K_REPLY;
    r_data = '0;
    r_port = '0;
    r_ak   = 1'b0;
    r_hl   = '0;
    r_err  = '0;
    case (head.op)
      CMD_REPLY2: begin
        r_data = (beat == '0) ? SOCKS_VER : METHOD_NONE;
      end
      CMD_REPLY10: begin
        r_data = reply_byte(beat, head.data);
      end
      CMD_REPLY10_ERR: begin
        if (beat == REPLY_LEN) begin
          r_kind = K_ERR;
          r_err  = head.err;
        end else begin
          r_data = reply_byte(beat, head.data);
        end
      end
      CMD_ADDR: begin
        r_kind = K_ADDR;
        r_data = head.data;
        r_ak   = head.ak;
      end
      CMD_DONE: begin
        r_kind = K_DONE;
        r_port = head.port;
        r_ak   = head.ak;
        r_hl   = head.hl;
      end
      default: begin
        r_kind = K_ERR;
        r_err  = head.err;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat      <= '0;
    end else begin
      out_valid <= out_valid_next;
      beat      <= beat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind        <= r_kind;
      data_byte   <= r_data;
      dest_port   <= r_port;
      addr_kind   <= r_ak;
      host_length <= r_hl;
      error_code  <= r_err;
      last        <= last_beat;
    end
  end

endmodule

FILE: sv/ssp_checker.sv
// Port-level assertions for the SOCKS5 handshake parser and their bind.
module ssp_checker import ssp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  kind,
  input logic [7:0]  data_byte,
  input logic [15:0] dest_port,
  input logic        last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(kind) && $stable(data_byte) && $stable(last)))
    else $error("stalled result changed");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == K_ERR) |-> (last && data_byte == 8'h00 && dest_port == 16'h0000))
    else $error("error item is not a clean final item");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && (kind == K_DONE || kind == K_ADDR)) |-> last)
    else $error("address or request item is not final");

endmodule

bind socks5_handshake_parser ssp_checker u_ssp_checker (
  .clk       (clk),
  .rst       (rst),
  .empty     (empty),
  .pop       (pop),
  .kind      (kind),
  .data_byte (data_byte),
  .dest_port (dest_port),
  .last      (last)
);
